[design/lkv_pkg.sv]
`default_nettype none

package lkv_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 64;

	localparam int KEY_BITS   = 64;
	localparam int WORD_BITS  = 64;
	localparam int OCC_BITS   = 5;
	localparam int COUNT_BITS = 32;
	localparam int LIMIT_BITS = 5;
	localparam int APB_DATA   = 32;
	localparam int APB_ADDR   = 3;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = 5'd16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

	// Register index taken from paddr[2].
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_STATS  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

[design/lru_key_value_cache_unit.sv]
`default_nettype none

// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_ready   opcode, key_high, key_low, value_word
// result    out        out_valid/out_ready hit, read_value, evicted, occupancy,
//                                          hit_total, miss_total
// config    in         APB write/read      cache_enable, capacity_limit
//
// An enabled lookup or insert compares one stored key per cycle, ending the scan early on
// a hit, then updates the store and loads its result; the next request is taken in the cycle
// after the load. Other requests go from acceptance straight to loading their result.
// Reset empties the store, clears the counters and restores the register defaults. A
// finished result waits while the output register holds an unaccepted one, and no request
// is taken until it has been loaded.
module lru_key_value_cache_unit
	import lkv_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR-1:0]   paddr,
	input  wire logic [APB_DATA-1:0]   pwdata,
	output logic      [APB_DATA-1:0]   prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            opcode,
	input  wire logic [KEY_BITS-1:0]   key_high,
	input  wire logic [KEY_BITS-1:0]   key_low,
	input  wire logic [WORD_BITS-1:0]  value_word,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       hit,
	output logic      [WORD_BITS-1:0]  read_value,
	output logic                       evicted,
	output logic      [OCC_BITS-1:0]   occupancy,
	output logic      [COUNT_BITS-1:0] hit_total,
	output logic      [COUNT_BITS-1:0] miss_total
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	state_t state_q, state_nx;

	logic                    enable_q;
	logic [LIMIT_BITS-1:0]   limit_q;

	op_t                     op_q;
	logic [2*KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0]   val_q;

	logic [2*KEY_BITS-1:0]   key_mem [CAPACITY];
	logic [VALUE_BITS-1:0]   val_mem [CAPACITY];
	logic [2*KEY_BITS-1:0]   key_rd_q;
	logic [VALUE_BITS-1:0]   val_rd_q;

	logic [CAPACITY-1:0]     valid_q;
	logic [IDX_W-1:0]        rank_q [CAPACITY];
	logic [CNT_W-1:0]        count_q;
	logic [COUNT_BITS-1:0]   hits_q;
	logic [COUNT_BITS-1:0]   misses_q;

	logic [IDX_W-1:0]        rd_idx_q;
	logic                    issue_q;
	logic                    cmp_vld_s1;
	logic [IDX_W-1:0]        cmp_idx_s1;

	logic                    hit_found_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic [IDX_W-1:0]        hit_rank_q;
	logic                    lru_found_q;
	logic [IDX_W-1:0]        lru_idx_q;
	logic [IDX_W-1:0]        lru_rank_q;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_idx_q;

	logic                    res_hit_q;
	logic                    res_ev_q;
	logic [VALUE_BITS-1:0]   res_val_q;

	logic                    out_valid_q;
	logic                    hit_out_q;
	logic [WORD_BITS-1:0]    read_value_q;
	logic                    evicted_q;
	logic [OCC_BITS-1:0]     occupancy_q;
	logic [COUNT_BITS-1:0]   hit_total_q;
	logic [COUNT_BITS-1:0]   miss_total_q;

	logic                    cfg_wr;
	logic                    accept;
	logic                    immediate;
	logic                    key_match;
	logic                    scan_last;
	logic                    load_out;
	logic                    is_ins;
	logic                    ins_new;
	logic                    do_evict;
	logic                    slot_ok;
	logic [IDX_W-1:0]        slot_c;
	logic [CMP_W-1:0]        eff_lim;
	logic [CAPACITY-1:0]     valid_nx;
	logic [IDX_W-1:0]        rank_nx [CAPACITY];
	logic [CNT_W-1:0]        count_nx;
	logic                    val_we;
	logic [IDX_W-1:0]        val_wr_addr;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_LIMIT) ? APB_DATA'(limit_q) : APB_DATA'(enable_q);
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign immediate = !enable_q || (op_t'(opcode) == OP_CLEAR) || (op_t'(opcode) == OP_STATS);

	assign key_match = cmp_vld_s1 && valid_q[cmp_idx_s1] && (key_rd_q == key_q);
	assign scan_last = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign load_out  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = immediate ? ST_FIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (key_match || scan_last) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (load_out) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ENABLE) begin
				enable_q <= pwdata[0];
			end else begin
				limit_q <= pwdata[LIMIT_BITS-1:0];
			end
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(opcode);
			key_q <= {key_high, key_low};
			val_q <= value_word[VALUE_BITS-1:0];
		end
	end

	// Scan address sequencer and compare stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			issue_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else if (state_q == ST_SCAN) begin
			if (issue_q) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				if (rd_idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end
			cmp_vld_s1 <= issue_q;
			cmp_idx_s1 <= rd_idx_q;
		end else begin
			rd_idx_q   <= '0;
			issue_q    <= 1'b1;
			cmp_vld_s1 <= 1'b0;
		end
	end

	// Search results gathered during the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (accept) begin
			hit_found_q  <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_q == ST_SCAN && cmp_vld_s1) begin
			if (key_match) begin
				hit_found_q <= 1'b1;
			end
			if (valid_q[cmp_idx_s1]) begin
				if (!lru_found_q || rank_q[cmp_idx_s1] > lru_rank_q) begin
					lru_found_q <= 1'b1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && cmp_vld_s1) begin
			if (key_match) begin
				hit_idx_q  <= cmp_idx_s1;
				hit_rank_q <= rank_q[cmp_idx_s1];
			end
			if (valid_q[cmp_idx_s1]) begin
				if (!lru_found_q || rank_q[cmp_idx_s1] > lru_rank_q) begin
					lru_idx_q  <= cmp_idx_s1;
					lru_rank_q <= rank_q[cmp_idx_s1];
				end
			end else if (!free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	// Update of the recency ranks, valid bits and occupancy.
	always_comb begin
		eff_lim  = (CMP_W'(limit_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(limit_q);
		is_ins   = (op_q == OP_INSERT);
		ins_new  = is_ins && !hit_found_q;
		do_evict = ins_new && lru_found_q && (CMP_W'(count_q) >= eff_lim);
		if (free_found_q && (!do_evict || free_idx_q < lru_idx_q)) begin
			slot_c = free_idx_q;
		end else begin
			slot_c = lru_idx_q;
		end
		slot_ok = ins_new && (free_found_q || do_evict);
		for (int i = 0; i < CAPACITY; i++) begin
			valid_nx[i] = valid_q[i];
			rank_nx[i]  = rank_q[i];
			if (hit_found_q) begin
				if (valid_q[i] && rank_q[i] < hit_rank_q) begin
					rank_nx[i] = rank_q[i] + 1'b1;
				end
				if (IDX_W'(i) == hit_idx_q) begin
					rank_nx[i] = '0;
				end
			end else if (ins_new) begin
				if (do_evict && IDX_W'(i) == lru_idx_q) begin
					valid_nx[i] = 1'b0;
					rank_nx[i]  = '0;
				end
				if (slot_ok) begin
					if (valid_nx[i]) begin
						rank_nx[i] = rank_nx[i] + 1'b1;
					end
					if (IDX_W'(i) == slot_c) begin
						valid_nx[i] = 1'b1;
						rank_nx[i]  = '0;
					end
				end
			end
		end
		count_nx = count_q - CNT_W'(do_evict) + CNT_W'(slot_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if ((cfg_wr && paddr[2] == REG_ENABLE && !pwdata[0])
				|| (accept && op_t'(opcode) == OP_CLEAR)) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (state_q == ST_UPDATE) begin
			valid_q <= valid_nx;
			count_q <= count_nx;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= rank_nx[i];
			end
		end
	end

	// Statistics counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
		end else if (accept) begin
			if (op_t'(opcode) == OP_CLEAR) begin
				hits_q   <= '0;
				misses_q <= '0;
			end else if (op_t'(opcode) == OP_LOOKUP && !enable_q && misses_q != COUNT_MAX) begin
				misses_q <= misses_q + 1'b1;
			end
		end else if (state_q == ST_UPDATE && op_q == OP_LOOKUP) begin
			if (hit_found_q) begin
				if (hits_q != COUNT_MAX) begin
					hits_q <= hits_q + 1'b1;
				end
			end else if (misses_q != COUNT_MAX) begin
				misses_q <= misses_q + 1'b1;
			end
		end
	end

	// Key and value memories.
	assign val_we      = (state_q == ST_UPDATE) && is_ins && (hit_found_q || slot_ok);
	assign val_wr_addr = hit_found_q ? hit_idx_q : slot_c;

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && slot_ok) begin
			key_mem[slot_c] <= key_q;
		end
		if (val_we) begin
			val_mem[val_wr_addr] <= val_q;
		end
		key_rd_q <= key_mem[rd_idx_q];
		val_rd_q <= val_mem[rd_idx_q];
	end

	// Per-request result flags.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_hit_q <= 1'b0;
			res_ev_q  <= 1'b0;
			res_val_q <= '0;
		end else if (state_q == ST_SCAN && key_match) begin
			if (op_q == OP_LOOKUP) begin
				res_val_q <= val_rd_q;
			end
		end else if (state_q == ST_UPDATE) begin
			res_hit_q <= hit_found_q;
			res_ev_q  <= do_evict;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_out_q    <= res_hit_q;
			read_value_q <= WORD_BITS'(res_val_q);
			evicted_q    <= res_ev_q;
			occupancy_q  <= OCC_BITS'(count_q);
			hit_total_q  <= hits_q;
			miss_total_q <= misses_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_out_q;
	assign read_value = read_value_q;
	assign evicted    = evicted_q;
	assign occupancy  = occupancy_q;
	assign hit_total  = hit_total_q;
	assign miss_total = miss_total_q;

endmodule

`default_nettype wire
